[rtl/elementwise_int_compare_mod_unit_macros.svh]
// assertion macros shared by the compare and remainder unit
`ifndef ELEMENTWISE_INT_COMPARE_MOD_UNIT_MACROS_SVH
`define ELEMENTWISE_INT_COMPARE_MOD_UNIT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define ECM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ecm check failed");

// consequent must hold in the cycle after the antecedent
`define ECM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ecm check failed");

`endif

[rtl/ecm_pkg.sv]
// shared types and constants of the compare and remainder unit
`default_nettype none
package ecm_pkg;

  // widths of the item fields and of the register port
  localparam int FIELD_W    = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int ECM_DATA_WIDTH = 32;

  // operation codes of op_mode
  typedef enum logic [2:0] {
    OP_REM  = 3'd0,
    OP_STEP = 3'd1,
    OP_EQ   = 3'd2,
    OP_LT   = 3'd3,
    OP_GT   = 3'd4
  } op_mode_t;

  // register indexes on the config port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OP_MODE        = 3'd0,
    REG_RHS_FROM_INPUT = 3'd1,
    REG_RHS_CONSTANT   = 3'd2,
    REG_THRESHOLD      = 3'd3,
    REG_TRUE_WORD      = 3'd4,
    REG_FALSE_WORD     = 3'd5,
    REG_ACCUMULATE_ON  = 3'd6,
    REG_SIGNED_DATA    = 3'd7
  } cfg_idx_t;

  // reset values of the registers
  localparam op_mode_t          RST_OP_MODE      = OP_STEP;
  localparam logic [FIELD_W-1:0] RST_RHS_CONSTANT = 32'd1;
  localparam logic [FIELD_W-1:0] RST_THRESHOLD    = 32'd0;
  localparam logic [FIELD_W-1:0] RST_TRUE_WORD    = 32'd1;
  localparam logic [FIELD_W-1:0] RST_FALSE_WORD   = 32'd0;

  // per-item flags that ride along the remainder pipeline
  typedef struct packed {
    logic is_rem;
    logic neg_a;
    logic div_zero;
  } ctrl_t;

endpackage
`default_nettype wire

[rtl/ecm_div_pipe.sv]
// pipelined restoring remainder unit, one quotient bit per stage
`default_nettype none
module ecm_div_pipe #(
  parameter int DATA_WIDTH = ecm_pkg::ECM_DATA_WIDTH
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [DATA_WIDTH-1:0] in_dividend,
  input  wire logic [DATA_WIDTH-1:0] in_divisor,
  input  wire ecm_pkg::ctrl_t        in_ctrl,
  input  wire logic [DATA_WIDTH-1:0] in_word,
  input  wire logic [DATA_WIDTH-1:0] in_prior,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [DATA_WIDTH-1:0]      out_rem,
  output ecm_pkg::ctrl_t             out_ctrl,
  output logic [DATA_WIDTH-1:0]      out_word,
  output logic [DATA_WIDTH-1:0]      out_prior
);
  import ecm_pkg::*;

  localparam int DW = DATA_WIDTH;

  // stage registers
  logic [DW-1:0] valid_r;
  logic [DW-1:0] rem_r   [DW];
  logic [DW-1:0] num_r   [DW];
  logic [DW-1:0] den_r   [DW];
  ctrl_t         ctrl_r  [DW];
  logic [DW-1:0] word_r  [DW];
  logic [DW-1:0] prior_r [DW];

  // a stage loads when it is empty or its item moves on
  logic [DW:0] rdy;
  assign rdy[DW] = out_ready;

  for (genvar k = 0; k < DW; k++) begin : g_stage
    logic          src_valid;
    logic [DW-1:0] src_rem;
    logic [DW-1:0] src_num;
    logic [DW-1:0] src_den;
    ctrl_t         src_ctrl;
    logic [DW-1:0] src_word;
    logic [DW-1:0] src_prior;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic [DW-1:0] rem_nxt;

    assign rdy[k] = !valid_r[k] || rdy[k+1];

    // source is the unit input for the first stage, else the stage before
    if (k == 0) begin : g_first
      assign src_valid = in_valid;
      assign src_rem   = '0;
      assign src_num   = in_dividend;
      assign src_den   = in_divisor;
      assign src_ctrl  = in_ctrl;
      assign src_word  = in_word;
      assign src_prior = in_prior;
    end else begin : g_next
      assign src_valid = valid_r[k-1];
      assign src_rem   = rem_r[k-1];
      assign src_num   = num_r[k-1];
      assign src_den   = den_r[k-1];
      assign src_ctrl  = ctrl_r[k-1];
      assign src_word  = word_r[k-1];
      assign src_prior = prior_r[k-1];
    end

    // shift in the next dividend bit and subtract the divisor if it fits
    assign trial   = {src_rem, src_num[DW-1]};
    assign diff    = trial - {1'b0, src_den};
    assign rem_nxt = diff[DW] ? trial[DW-1:0] : diff[DW-1:0];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[k] <= 1'b0;
      end else if (rdy[k]) begin
        valid_r[k] <= src_valid;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k] && src_valid) begin
        rem_r[k]   <= rem_nxt;
        num_r[k]   <= {src_num[DW-2:0], 1'b0};
        den_r[k]   <= src_den;
        ctrl_r[k]  <= src_ctrl;
        word_r[k]  <= src_word;
        prior_r[k] <= src_prior;
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = valid_r[DW-1];
  assign out_rem   = rem_r[DW-1];
  assign out_ctrl  = ctrl_r[DW-1];
  assign out_word  = word_r[DW-1];
  assign out_prior = prior_r[DW-1];

endmodule
`default_nettype wire

[rtl/elementwise_int_compare_mod_unit.sv]
// Element-wise integer compare and remainder unit. Each item (left operand,
// right operand, prior element) gives one result word: truncated remainder,
// step against a threshold, or equal/less/greater selecting the true or false
// word (other op codes select the false word), optionally added to the prior
// element. The unit takes one item per clock while in_stall is low and holds
// DATA_WIDTH + 4 items in flight. The depth is set by the remainder pipeline,
// which resolves one quotient bit per stage. Stages with no item fill up
// while the output is stalled, so in_stall rises only once every stage holds
// an item. Configuration is written through cfg_* with cfg_ready always high,
// and must only change while no item is in flight.
`default_nettype none
`include "elementwise_int_compare_mod_unit_macros.svh"
module elementwise_int_compare_mod_unit #(
  parameter int DATA_WIDTH = ecm_pkg::ECM_DATA_WIDTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // input items
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [ecm_pkg::FIELD_W-1:0]   in_lhs_value,
  input  wire logic [ecm_pkg::FIELD_W-1:0]   in_rhs_value,
  input  wire logic [ecm_pkg::FIELD_W-1:0]   in_prior_value,
  // result items
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [ecm_pkg::FIELD_W-1:0]        out_result_value,
  // register writes
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [ecm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ecm_pkg::FIELD_W-1:0]   cfg_data
);
  import ecm_pkg::*;

  localparam int DW = DATA_WIDTH;

  // configuration registers
  op_mode_t           op_mode_r;
  logic               rhs_from_input_r;
  logic [FIELD_W-1:0] rhs_constant_r;
  logic [FIELD_W-1:0] threshold_r;
  logic [FIELD_W-1:0] true_word_r;
  logic [FIELD_W-1:0] false_word_r;
  logic               accumulate_on_r;
  logic               signed_data_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_mode_r        <= RST_OP_MODE;
      rhs_from_input_r <= 1'b0;
      rhs_constant_r   <= RST_RHS_CONSTANT;
      threshold_r      <= RST_THRESHOLD;
      true_word_r      <= RST_TRUE_WORD;
      false_word_r     <= RST_FALSE_WORD;
      accumulate_on_r  <= 1'b0;
      signed_data_r    <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_OP_MODE:        op_mode_r        <= op_mode_t'(cfg_data[2:0]);
        REG_RHS_FROM_INPUT: rhs_from_input_r <= cfg_data[0];
        REG_RHS_CONSTANT:   rhs_constant_r   <= cfg_data;
        REG_THRESHOLD:      threshold_r      <= cfg_data;
        REG_TRUE_WORD:      true_word_r      <= cfg_data;
        REG_FALSE_WORD:     false_word_r     <= cfg_data;
        REG_ACCUMULATE_ON:  accumulate_on_r  <= cfg_data[0];
        REG_SIGNED_DATA:    signed_data_r    <= cfg_data[0];
      endcase
    end
  end

  // ready chain from the output back to the input
  logic rdy_a, rdy_b, rdy_c, rdy_d, div_in_ready;

  // stage a: capture operands at data width, right operand selected
  logic          a_valid_r;
  logic [DW-1:0] a_lhs_r, a_rhs_r, a_prior_r;

  assign rdy_a    = !a_valid_r || rdy_b;
  assign in_stall = !rdy_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (rdy_a) begin
      a_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a && in_valid) begin
      a_lhs_r   <= DW'(in_lhs_value);
      a_rhs_r   <= rhs_from_input_r ? DW'(in_rhs_value) : DW'(rhs_constant_r);
      a_prior_r <= DW'(in_prior_value);
    end
  end

  // stage b: magnitudes for the remainder, compare and word select
  logic          b_valid_r;
  logic [DW-1:0] b_mag_a_r, b_mag_b_r, b_word_r, b_prior_r;
  ctrl_t         b_ctrl_r;

  logic [DW-1:0] sign_flip;
  logic [DW-1:0] lhs_key, rhs_key, thr_key;
  logic          neg_a, neg_b, cond;
  logic [DW-1:0] mag_a, mag_b;
  ctrl_t         b_ctrl_nxt;

  assign sign_flip = {signed_data_r, {(DW-1){1'b0}}};
  assign lhs_key   = a_lhs_r ^ sign_flip;
  assign rhs_key   = a_rhs_r ^ sign_flip;
  assign thr_key   = DW'(threshold_r) ^ sign_flip;
  assign neg_a     = signed_data_r && a_lhs_r[DW-1];
  assign neg_b     = signed_data_r && a_rhs_r[DW-1];
  assign mag_a     = neg_a ? {DW{1'b0}} - a_lhs_r : a_lhs_r;
  assign mag_b     = neg_b ? {DW{1'b0}} - a_rhs_r : a_rhs_r;

  always_comb begin
    unique case (op_mode_r)
      OP_STEP: cond = lhs_key >= thr_key;
      OP_EQ:   cond = lhs_key == rhs_key;
      OP_LT:   cond = lhs_key <  rhs_key;
      OP_GT:   cond = lhs_key >  rhs_key;
      default: cond = 1'b0;
    endcase
  end

  always_comb begin
    b_ctrl_nxt          = '0;
    b_ctrl_nxt.is_rem   = (op_mode_r == OP_REM);
    b_ctrl_nxt.neg_a    = neg_a;
    b_ctrl_nxt.div_zero = (a_rhs_r == '0);
  end

  assign rdy_b = !b_valid_r || div_in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (rdy_b) begin
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_b && a_valid_r) begin
      b_mag_a_r <= mag_a;
      b_mag_b_r <= mag_b;
      b_ctrl_r  <= b_ctrl_nxt;
      b_word_r  <= cond ? DW'(true_word_r) : DW'(false_word_r);
      b_prior_r <= a_prior_r;
    end
  end

  // remainder pipeline
  logic          div_valid;
  logic [DW-1:0] div_rem, div_word, div_prior;
  ctrl_t         div_ctrl;

  ecm_div_pipe #(
    .DATA_WIDTH (DW)
  ) u_div (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (b_valid_r),
    .in_ready    (div_in_ready),
    .in_dividend (b_mag_a_r),
    .in_divisor  (b_mag_b_r),
    .in_ctrl     (b_ctrl_r),
    .in_word     (b_word_r),
    .in_prior    (b_prior_r),
    .out_valid   (div_valid),
    .out_ready   (rdy_c),
    .out_rem     (div_rem),
    .out_ctrl    (div_ctrl),
    .out_word    (div_word),
    .out_prior   (div_prior)
  );

  // stage c: remainder sign follows the dividend, pick the value
  logic          c_valid_r;
  logic [DW-1:0] c_value_r, c_prior_r;
  logic [DW-1:0] rem_signed, c_value_nxt;

  assign rem_signed = div_ctrl.neg_a ? {DW{1'b0}} - div_rem : div_rem;

  always_comb begin
    if (!div_ctrl.is_rem) begin
      c_value_nxt = div_word;
    end else if (div_ctrl.div_zero) begin
      c_value_nxt = '0;
    end else begin
      c_value_nxt = rem_signed;
    end
  end

  assign rdy_c = !c_valid_r || rdy_d;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
    end else if (rdy_c) begin
      c_valid_r <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_c && div_valid) begin
      c_value_r <= c_value_nxt;
      c_prior_r <= div_prior;
    end
  end

  // stage d: output register, with the prior element added when accumulation is on
  logic          out_valid_r;
  logic [DW-1:0] out_result_r;

  assign rdy_d = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rdy_d) begin
      out_valid_r <= c_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_d && c_valid_r) begin
      out_result_r <= accumulate_on_r ? c_prior_r + c_value_r : c_value_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = FIELD_W'(out_result_r);

  // checks
  `ECM_ASSERT_NEXT(a_takes_item, in_valid && !in_stall, a_valid_r)
  `ECM_ASSERT_NEXT(b_holds_on_stall, b_valid_r && !div_in_ready,
                   b_valid_r && $stable(b_mag_a_r) && $stable(b_word_r))
  `ECM_ASSERT_NEXT(c_moves_to_out, c_valid_r && rdy_d, out_valid_r)
  `ECM_ASSERT_NOW(stall_only_when_full, in_stall, a_valid_r && b_valid_r)

endmodule
`default_nettype wire

[tb/elementwise_int_compare_mod_unit_tb.sv]
// testbench for the element-wise integer compare and remainder unit
module elementwise_int_compare_mod_unit_tb;
  import ecm_pkg::*;

  typedef logic [FIELD_W-1:0] word_t;

  // op_mode codes the block does not define
  localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

  // cycles to let pass once the last result is in, and the watchdog limit
  localparam int PIPE_SETTLE = ECM_DATA_WIDTH + 8;
  localparam int HANG_LIMIT  = 2000;

  // register copy used by the predictor
  typedef struct {
    logic [2:0] op;
    logic       rhs_in;
    word_t      rhs_const;
    word_t      thresh;
    word_t      t_word;
    word_t      f_word;
    logic       acc;
    logic       sgn;
  } unit_cfg_t;

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  in_valid = 1'b0;
  logic  in_stall;
  word_t in_lhs_value = '0;
  word_t in_rhs_value = '0;
  word_t in_prior_value = '0;
  logic  out_valid;
  logic  out_stall = 1'b0;
  word_t out_result_value;
  logic  cfg_valid = 1'b0;
  logic  cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  word_t cfg_data = '0;

  unit_cfg_t regs;
  word_t     expected_results[$];
  int        err_cnt = 0;
  int        idle_cycles = 0;
  int        sender_idle_pct = 18;
  int        receiver_stall_pct = 76;

  elementwise_int_compare_mod_unit uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_lhs_value     (in_lhs_value),
    .in_rhs_value     (in_rhs_value),
    .in_prior_value   (in_prior_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_value (out_result_value),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // clock
  always #5 clk = ~clk;

  // ordered compare under the current signedness
  function automatic logic word_less(input word_t a, input word_t b);
    if (regs.sgn) return $signed(a) < $signed(b);
    return a < b;
  endfunction

  // expected result word of one item under the current registers
  function automatic word_t compute_result(input word_t lhs, input word_t rhs_item,
                                           input word_t prior);
    word_t rhs, val, mag_a, mag_b;
    logic  hit;
    rhs = regs.rhs_in ? rhs_item : regs.rhs_const;
    hit = 1'b0;
    if (regs.op == OP_REM) begin
      if (rhs == '0) val = '0;
      else if (!regs.sgn) val = lhs % rhs;
      else if (rhs == '1) val = '0;
      else begin
        // truncating division: remainder takes the sign of the dividend
        mag_a = lhs[FIELD_W-1] ? -lhs : lhs;
        mag_b = rhs[FIELD_W-1] ? -rhs : rhs;
        val = mag_a % mag_b;
        if (lhs[FIELD_W-1]) val = -val;
      end
    end else begin
      case (regs.op)
        OP_STEP: hit = !word_less(lhs, regs.thresh);
        OP_EQ:   hit = (lhs == rhs);
        OP_LT:   hit = word_less(lhs, rhs);
        OP_GT:   hit = word_less(rhs, lhs);
        default: hit = 1'b0;
      endcase
      val = hit ? regs.t_word : regs.f_word;
    end
    if (regs.acc) val = val + prior;
    return val;
  endfunction

  // operand words biased toward the corners
  function automatic word_t edge_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return 32'h8000_0000;
      3:       return 32'h7FFF_FFFF;
      4:       return word_t'($urandom_range(0, 16));
      5:       return -word_t'($urandom_range(1, 16));
      default: return $urandom;
    endcase
  endfunction

  function automatic unit_cfg_t make_cfg(input logic [2:0] op, input logic rhs_in,
                                         input word_t rhs_const, input word_t thresh,
                                         input word_t t_word, input word_t f_word,
                                         input logic acc, input logic sgn);
    unit_cfg_t c;
    c.op = op;
    c.rhs_in = rhs_in;
    c.rhs_const = rhs_const;
    c.thresh = thresh;
    c.t_word = t_word;
    c.f_word = f_word;
    c.acc = acc;
    c.sgn = sgn;
    return c;
  endfunction

  function automatic unit_cfg_t random_cfg();
    logic [2:0] op;
    if ($urandom_range(0, 9) != 0) op = 3'($urandom_range(OP_REM, OP_GT));
    else op = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
    return make_cfg(op, 1'($urandom), edge_word(), edge_word(),
                    ($urandom_range(0, 1) != 0) ? $urandom : edge_word(), edge_word(),
                    1'($urandom), 1'($urandom));
  endfunction

  // mismatch report
  task automatic report_mismatch(input string what, input word_t got, input word_t want);
    $display("mismatch: %s, got %h want %h at %0t", what, got, want, $realtime);
    err_cnt++;
  endtask

  // one register write, mirrored into the predictor copy on acceptance
  task automatic write_reg(input cfg_idx_t idx, input word_t data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_OP_MODE:        regs.op = data[2:0];
      REG_RHS_FROM_INPUT: regs.rhs_in = data[0];
      REG_RHS_CONSTANT:   regs.rhs_const = data;
      REG_THRESHOLD:      regs.thresh = data;
      REG_TRUE_WORD:      regs.t_word = data;
      REG_FALSE_WORD:     regs.f_word = data;
      REG_ACCUMULATE_ON:  regs.acc = data[0];
      REG_SIGNED_DATA:    regs.sgn = data[0];
      default: ;
    endcase
  endtask

  // stop sending and wait until every expected result is back
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (PIPE_SETTLE) @(posedge clk);
  endtask

  // idle the unit, then write every register
  task automatic apply_config(input unit_cfg_t c);
    wait_for_results();
    write_reg(REG_OP_MODE, word_t'(c.op));
    write_reg(REG_RHS_FROM_INPUT, word_t'(c.rhs_in));
    write_reg(REG_RHS_CONSTANT, c.rhs_const);
    write_reg(REG_THRESHOLD, c.thresh);
    write_reg(REG_TRUE_WORD, c.t_word);
    write_reg(REG_FALSE_WORD, c.f_word);
    write_reg(REG_ACCUMULATE_ON, word_t'(c.acc));
    write_reg(REG_SIGNED_DATA, word_t'(c.sgn));
    cfg_valid <= 1'b0;
  endtask

  // send one item; valid stays high so back-to-back items need no reassertion
  task automatic send_item(input word_t lhs, input word_t rhs, input word_t prior);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_lhs_value   <= lhs;
    in_rhs_value   <= rhs;
    in_prior_value <= prior;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_results.push_back(compute_result(lhs, rhs, prior));
  endtask

  // result checker
  always @(posedge clk) begin : check_results
    word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with no item outstanding", out_result_value, '0);
      end else begin
        want = expected_results.pop_front();
        if (out_result_value !== want)
          report_mismatch("result_value", out_result_value, want);
      end
    end
  end

  // receiver stall
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
  end

  // watchdog on handshake activity
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= HANG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", HANG_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // reset values: step against threshold zero is always true
  task automatic test_reset_values();
    regs = make_cfg(OP_STEP, 1'b0, RST_RHS_CONSTANT, RST_THRESHOLD,
                    RST_TRUE_WORD, RST_FALSE_WORD, 1'b0, 1'b0);
    send_item('0, '1, 32'h1234_5678);
    send_item('1, '0, '1);
  endtask

  // remainder: zero divisor, minus one divisor, sign of the dividend
  task automatic test_remainder();
    apply_config(make_cfg(OP_REM, 1'b1, '0, '0, '1, '0, 1'b0, 1'b0));
    send_item(32'd7, 32'd3, '0);
    send_item('1, 32'd10, '0);
    send_item(32'd5, '0, '0);
    send_item('0, '1, '0);
    apply_config(make_cfg(OP_REM, 1'b1, '0, '0, '1, '0, 1'b0, 1'b1));
    send_item(-word_t'(7), 32'd2, '0);
    send_item(32'd7, -word_t'(2), '0);
    send_item(32'h8000_0000, '1, '0);
    send_item(32'h8000_0000, 32'h7FFF_FFFF, '0);
    send_item(32'd5, '0, '0);
    // divisor from the constant register
    apply_config(make_cfg(OP_REM, 1'b0, 32'h8000_0000, '0, '1, '0, 1'b0, 1'b0));
    send_item('1, 32'd3, '0);
  endtask

  // step, equal, less, greater and an undefined op code
  task automatic test_compare_modes();
    apply_config(make_cfg(OP_STEP, 1'b1, '0, '0, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 1'b0, 1'b1));
    send_item('1, '0, '0);
    send_item('0, '1, '0);
    apply_config(make_cfg(OP_EQ, 1'b1, '0, '0, '1, '0, 1'b0, 1'b1));
    send_item(32'd3, 32'd3, '0);
    send_item(32'd3, 32'd4, '0);
    apply_config(make_cfg(OP_LT, 1'b1, '0, '0, '1, '0, 1'b0, 1'b1));
    send_item(32'h8000_0000, 32'h7FFF_FFFF, '0);
    apply_config(make_cfg(OP_LT, 1'b1, '0, '0, '1, '0, 1'b0, 1'b0));
    send_item(32'h8000_0000, 32'h7FFF_FFFF, '0);
    apply_config(make_cfg(OP_GT, 1'b0, '0, '0, 32'h0000_0001, '1, 1'b0, 1'b0));
    send_item('1, '1, '0);
    apply_config(make_cfg(OP_SPARE_LAST, 1'b1, '0, '0, '1, 32'hDEAD_BEEF, 1'b0, 1'b0));
    send_item(32'd9, 32'd9, '0);
  endtask

  // accumulation wraps at the data width
  task automatic test_accumulate();
    apply_config(make_cfg(OP_REM, 1'b1, '0, '0, '1, '0, 1'b1, 1'b0));
    send_item(32'd7, 32'd3, '1);
    apply_config(make_cfg(OP_EQ, 1'b1, '0, '0, '1, '0, 1'b1, 1'b1));
    send_item(32'd4, 32'd4, 32'd1);
  endtask

  // random configurations, each followed by a burst of random items
  task automatic test_random_traffic(input int send_pct, input int stall_pct, input int n_items);
    unit_cfg_t c;
    int left, chunk;
    word_t lhs, rhs;
    sender_idle_pct = send_pct;
    receiver_stall_pct = stall_pct;
    left = n_items;
    while (left > 0) begin
      chunk = $urandom_range(10, 60);
      if (chunk > left) chunk = left;
      c = random_cfg();
      apply_config(c);
      repeat (chunk) begin
        lhs = edge_word();
        rhs = ($urandom_range(0, 3) == 0) ? lhs : edge_word();
        // hit the equality points of the constant and the threshold
        case ($urandom_range(0, 7))
          0:       lhs = c.rhs_const;
          1:       lhs = c.thresh;
          default: ;
        endcase
        send_item(lhs, rhs, edge_word());
      end
      left -= chunk;
    end
  endtask

  // test sequence
  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_values();
    test_remainder();
    test_compare_modes();
    test_accumulate();
    test_random_traffic(18, 76, 542);
    test_random_traffic(76, 18, 542);
    test_random_traffic(0, 0, 542);
    wait_for_results();
    if (err_cnt == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/ecm_pkg.sv
rtl/ecm_div_pipe.sv
rtl/elementwise_int_compare_mod_unit.sv
tb/elementwise_int_compare_mod_unit_tb.sv
